// ===== design/sprite_transparency_rle_encoder_macros.svh =====
// Assertion macros for the port-level checker of the sprite RLE encoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SPRITE_TRANSPARENCY_RLE_ENCODER_MACROS_SVH
`define SPRITE_TRANSPARENCY_RLE_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STRLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STRLE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/strle_pkg.sv =====
// Package of the sprite RLE encoder: widths, limits, byte codes and the command type.
// Depends on nothing; every other design file but strle_ram and the macro header imports it.
`default_nettype none

package strle_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 13;
  localparam int CHUNK_BYTES = 8;
  localparam int CHUNK_W     = CHUNK_BYTES * PIX_W;
  localparam int CNT_W       = $clog2(CHUNK_BYTES);
  localparam int BC_W        = CNT_W + 1;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  localparam int MAX_RUN   = 127;
  localparam int RUN_W     = 7;
  localparam int NUM_BANKS = 2;
  localparam int RAM_AW    = RUN_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [PIX_W-1:0] CLEAR_FLAG   = 8'h80;
  localparam logic [PIX_W-1:0] ROW_END_MARK = 8'h80;

  // One command describes every byte caused by one pixel.
  typedef struct packed {
    logic             a_op;     // opaque run flushed before the pixel
    logic             a_clr;    // transparent run flushed before the pixel
    logic [RUN_W-1:0] a_len;
    logic             a_bank;
    logic             b_op;     // opaque run flushed at row end
    logic [RUN_W-1:0] b_len;
    logic             b_bank;
    logic             row_end;  // row end marker follows
  } strle_cmd_t;

endpackage

`default_nettype wire

// ===== design/sprite_transparency_rle_encoder.sv =====
// Top level of the sprite RLE encoder: front end, command queue, run buffer RAM, back end.
// Depends on strle_pkg, strle_front, strle_queue, strle_ram and strle_back.
`default_nettype none

// Transparent run-length sprite encoder. Palette pixels are pushed one per
// transaction, row by row; cfg_wr_data sets the row width (zero acts as one,
// values above 4096 act as 4096). The user writes it only while the block is idle;
// the block does not enforce this. Each row is cut into runs of up to 127 pixels.
// An opaque run is sent as its length byte and its pixel bytes, a transparent
// run as 0x80 plus its length (dropped when it ends the row), and every row ends
// with the byte 0x80. The bytes caused by one pixel leave as 8-byte chunks, first
// byte in the low bits, unused high bytes zero; out_last_of_burst marks the final
// chunk of a pixel and out_row_done the chunk holding the row end marker.
// Timing: the front end takes one pixel per cycle while in_full is low and writes
// it into one of two 128-byte run buffer banks; a pixel that causes bytes puts one
// command into a four-entry queue. The back end emits one encoded byte per cycle
// while its packer can take bytes; a chunk leaves every eight bytes or at the end of
// a burst. in_full rises when the queue is full or when the bank the next pixel
// needs is still being read out. The run buffer needs no clearing after reset:
// only bytes written in the current run are read.
module sprite_transparency_rle_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [strle_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [strle_pkg::PIX_W-1:0]       in_pixel,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [strle_pkg::CHUNK_W-1:0]     out_chunk,
  output logic [strle_pkg::BC_W-1:0]        out_byte_count,
  output logic                              out_row_done,
  output logic                              out_last_of_burst
);
  import strle_pkg::*;

  // Front end to queue.
  logic                 q_full, q_push, q_empty, q_pop;
  strle_cmd_t           q_cmd, q_head;

  // Run buffer: the front end writes the pending run, the back end reads flushed runs.
  logic                 mem_we, mem_re;
  logic [RAM_AW-1:0]    mem_waddr, mem_raddr;
  logic [PIX_W-1:0]     mem_wdata, mem_rdata;

  // A bank stays busy from its flush until the back end has issued its last read.
  logic [NUM_BANKS-1:0] busy, busy_clr;

  strle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_pixel    (in_pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .busy_clr    (busy_clr),
    .busy        (busy)
  );

  strle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  strle_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_run_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  strle_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .busy_clr          (busy_clr),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_chunk         (out_chunk),
    .out_byte_count    (out_byte_count),
    .out_row_done      (out_row_done),
    .out_last_of_burst (out_last_of_burst)
  );

endmodule

`default_nettype wire

// ===== design/strle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module strle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;
  logic [AW-1:0]    raddr_w;

  assign raddr_w = raddr;
  assign rdata   = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr_w];
    end
  end

endmodule

`default_nettype wire

// ===== design/strle_front.sv =====
// Front end of the sprite RLE encoder: row width register, run tracking, run buffer writes.
// Depends on strle_pkg; emits one strle_cmd_t per pixel that causes output bytes.
`default_nettype none

module strle_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [strle_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [strle_pkg::PIX_W-1:0]           in_pixel,
  input  logic                                  q_full,
  output logic                                  q_push,
  output strle_pkg::strle_cmd_t                 q_cmd,
  output logic                                  mem_we,
  output logic [strle_pkg::RAM_AW-1:0]          mem_waddr,
  output logic [strle_pkg::PIX_W-1:0]           mem_wdata,
  input  logic [strle_pkg::NUM_BANKS-1:0]       busy_clr,
  output logic [strle_pkg::NUM_BANKS-1:0]       busy
);
  import strle_pkg::*;

  localparam logic [CFG_W-1:0] MaxWidthV = CFG_W'(MAX_WIDTH);
  localparam logic [RUN_W-1:0] MaxRunV   = RUN_W'(MAX_RUN);

  logic [CFG_W-1:0]     row_width_r;
  logic [RUN_W-1:0]     run_len_r, run_len_nxt;
  logic                 run_clr_r, run_clr_nxt;
  logic [COL_W-1:0]     column_r, column_nxt;
  logic                 bank_r, bank_nxt;
  logic [NUM_BANKS-1:0] busy_r, busy_set;

  logic             accept, clear, flush_a, bank1, clr1, row_end;
  logic [RUN_W-1:0] len1, len2;
  logic [CFG_W-1:0] width_eff, col_plus;
  strle_cmd_t       cmd;

  assign busy  = busy_r;
  assign clear = (in_pixel == '0);

  // A pixel may flush an opaque run and move to the other bank, so both banks must be free then.
  assign in_full = q_full || busy_r[bank_r] ||
                   (busy_r[~bank_r] && (run_len_r != '0) && !run_clr_r);
  assign accept  = in_push && !in_full;

  always_comb begin
    if (row_width_r == '0) begin
      width_eff = CFG_W'(1);
    end else if (row_width_r > MaxWidthV) begin
      width_eff = MaxWidthV;
    end else begin
      width_eff = row_width_r;
    end
  end

  always_comb begin
    flush_a  = (run_len_r != '0) && ((clear != run_clr_r) || (run_len_r >= MaxRunV));
    bank1    = (flush_a && !run_clr_r) ? ~bank_r : bank_r;
    len1     = flush_a ? '0 : run_len_r;
    clr1     = (len1 == '0) ? clear : run_clr_r;
    len2     = len1 + RUN_W'(1);
    col_plus = CFG_W'(column_r) + CFG_W'(1);
    row_end  = (col_plus >= width_eff);

    cmd.a_op    = flush_a && !run_clr_r;
    cmd.a_clr   = flush_a && run_clr_r;
    cmd.a_len   = run_len_r;
    cmd.a_bank  = bank_r;
    cmd.b_op    = row_end && !clr1;
    cmd.b_len   = len2;
    cmd.b_bank  = bank1;
    cmd.row_end = row_end;

    if (row_end) begin
      run_len_nxt = '0;
      run_clr_nxt = clr1;
      bank_nxt    = cmd.b_op ? ~bank1 : bank1;
      column_nxt  = '0;
    end else begin
      run_len_nxt = len2;
      run_clr_nxt = clr1;
      bank_nxt    = bank1;
      column_nxt  = COL_W'(col_plus);
    end

    busy_set = '0;
    if (accept && cmd.a_op) begin
      busy_set[cmd.a_bank] = 1'b1;
    end
    if (accept && cmd.b_op) begin
      busy_set[cmd.b_bank] = 1'b1;
    end
  end

  assign q_push    = accept && (cmd.a_op || cmd.a_clr || cmd.row_end);
  assign q_cmd     = cmd;
  assign mem_we    = accept;
  assign mem_waddr = {bank1, len1};
  assign mem_wdata = in_pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= CFG_W'(1);
      run_len_r   <= '0;
      run_clr_r   <= 1'b0;
      column_r    <= '0;
      bank_r      <= 1'b0;
      busy_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_width_r <= cfg_wr_data;
      end
      if (accept) begin
        run_len_r <= run_len_nxt;
        run_clr_r <= run_clr_nxt;
        column_r  <= column_nxt;
        bank_r    <= bank_nxt;
      end
      busy_r <= (busy_r & ~busy_clr) | busy_set;
    end
  end

endmodule

`default_nettype wire

// ===== design/strle_queue.sv =====
// Short command queue between the front and back ends of the sprite RLE encoder.
// Depends on strle_pkg for the command type and depth.
`default_nettype none

module strle_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  strle_pkg::strle_cmd_t push_cmd,
  output logic                  full,
  input  logic                  pop,
  output strle_pkg::strle_cmd_t head,
  output logic                  empty
);
  import strle_pkg::*;

  strle_cmd_t       slot_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == Q_CW'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/strle_back.sv =====
// Back end of the sprite RLE encoder: byte sequencer over commands and the 8-byte chunk packer.
// Depends on strle_pkg; reads run bytes from the run buffer RAM.
`default_nettype none

module strle_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  strle_pkg::strle_cmd_t               q_head,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                mem_re,
  output logic [strle_pkg::RAM_AW-1:0]        mem_raddr,
  input  logic [strle_pkg::PIX_W-1:0]         mem_rdata,
  output logic [strle_pkg::NUM_BANKS-1:0]     busy_clr,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [strle_pkg::CHUNK_W-1:0]       out_chunk,
  output logic [strle_pkg::BC_W-1:0]          out_byte_count,
  output logic                                out_row_done,
  output logic                                out_last_of_burst
);
  import strle_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_AHDR = 7'b0000010,
    PH_ADAT = 7'b0000100,
    PH_ACLR = 7'b0001000,
    PH_BHDR = 7'b0010000,
    PH_BDAT = 7'b0100000,
    PH_MARK = 7'b1000000
  } phase_t;

  function automatic phase_t first_phase(input strle_cmd_t c);
    if (c.a_op) begin
      return PH_AHDR;
    end else if (c.a_clr) begin
      return PH_ACLR;
    end else if (c.b_op) begin
      return PH_BHDR;
    end else begin
      return PH_MARK;
    end
  endfunction

  function automatic phase_t after_a(input strle_cmd_t c);
    if (c.b_op) begin
      return PH_BHDR;
    end else if (c.row_end) begin
      return PH_MARK;
    end else begin
      return PH_IDLE;
    end
  endfunction

  phase_t               phase_r, phase_nxt, step_nxt;
  strle_cmd_t           ent_r;
  logic [RUN_W-1:0]     idx_r, idx_nxt;
  logic [PIX_W-1:0]     byte_val;
  logic                 from_mem, last, adv, load;
  logic [NUM_BANKS-1:0] clr;

  logic                 s2_valid_r, s2_mem_r, s2_last_r, s2_row_r;
  logic [PIX_W-1:0]     s2_byte_r, s2_data;

  logic [CHUNK_W-1:0]   acc_r, acc_with;
  logic [CNT_W-1:0]     acc_cnt_r;
  logic                 completes, can_take, take, popped;

  logic                 out_valid_r, out_row_r, out_last_r;
  logic [CHUNK_W-1:0]   out_chunk_r;
  logic [BC_W-1:0]      out_count_r;

  // Sequencer: one encoded byte per step.
  always_comb begin
    byte_val  = '0;
    from_mem  = 1'b0;
    mem_raddr = {ent_r.a_bank, idx_r};
    step_nxt  = phase_r;
    idx_nxt   = idx_r;
    clr       = '0;
    unique case (phase_r)
      PH_IDLE: begin
        step_nxt = PH_IDLE;
      end
      PH_AHDR: begin
        byte_val = PIX_W'(ent_r.a_len);
        step_nxt = PH_ADAT;
      end
      PH_ADAT: begin
        from_mem  = 1'b1;
        mem_raddr = {ent_r.a_bank, idx_r};
        if (idx_r == ent_r.a_len - RUN_W'(1)) begin
          step_nxt           = after_a(ent_r);
          idx_nxt            = '0;
          clr[ent_r.a_bank]  = 1'b1;
        end else begin
          idx_nxt = idx_r + RUN_W'(1);
        end
      end
      PH_ACLR: begin
        byte_val = CLEAR_FLAG | PIX_W'(ent_r.a_len);
        step_nxt = after_a(ent_r);
      end
      PH_BHDR: begin
        byte_val = PIX_W'(ent_r.b_len);
        step_nxt = PH_BDAT;
      end
      PH_BDAT: begin
        from_mem  = 1'b1;
        mem_raddr = {ent_r.b_bank, idx_r};
        if (idx_r == ent_r.b_len - RUN_W'(1)) begin
          step_nxt          = PH_MARK;
          idx_nxt           = '0;
          clr[ent_r.b_bank] = 1'b1;
        end else begin
          idx_nxt = idx_r + RUN_W'(1);
        end
      end
      PH_MARK: begin
        byte_val = ROW_END_MARK;
        step_nxt = PH_IDLE;
      end
      default: begin
        step_nxt = PH_IDLE;
      end
    endcase
  end

  assign last = (phase_r != PH_IDLE) && (step_nxt == PH_IDLE);

  // Packer: a byte is taken unless it closes a chunk while the output register stays full.
  assign popped    = out_pop && out_valid_r;
  assign s2_data   = s2_mem_r ? mem_rdata : s2_byte_r;
  assign completes = (acc_cnt_r == CNT_W'(CHUNK_BYTES - 1)) || s2_last_r;
  assign can_take  = !completes || !out_valid_r || popped;
  assign take      = s2_valid_r && can_take;
  assign adv       = !s2_valid_r || can_take;
  assign acc_with  = acc_r | (CHUNK_W'(s2_data) << {acc_cnt_r, 3'b000});

  assign load     = !q_empty && ((phase_r == PH_IDLE) || (adv && last));
  assign q_pop    = load;
  assign mem_re   = adv && from_mem;
  assign busy_clr = adv ? clr : '0;

  always_comb begin
    if (load) begin
      phase_nxt = first_phase(q_head);
    end else if (adv) begin
      phase_nxt = step_nxt;
    end else begin
      phase_nxt = phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= q_head;
    end
    if (adv) begin
      s2_mem_r  <= from_mem;
      s2_byte_r <= byte_val;
      s2_last_r <= last;
      s2_row_r  <= ent_r.row_end;
    end
    if (take && completes) begin
      out_chunk_r <= acc_with;
      out_count_r <= BC_W'(acc_cnt_r) + BC_W'(1);
      out_row_r   <= s2_last_r && s2_row_r;
      out_last_r  <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      s2_valid_r  <= 1'b0;
      acc_r       <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (adv && (phase_r != PH_IDLE)) begin
        idx_r <= idx_nxt;
      end
      if (adv) begin
        s2_valid_r <= (phase_r != PH_IDLE);
      end
      if (take) begin
        if (completes) begin
          acc_r     <= '0;
          acc_cnt_r <= '0;
        end else begin
          acc_r     <= acc_with;
          acc_cnt_r <= acc_cnt_r + CNT_W'(1);
        end
      end
      if (take && completes) begin
        out_valid_r <= 1'b1;
      end else if (popped) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_chunk         = out_chunk_r;
  assign out_byte_count    = out_count_r;
  assign out_row_done      = out_row_r;
  assign out_last_of_burst = out_last_r;

endmodule

`default_nettype wire

// ===== design/strle_checker.sv =====
// Port-level checker for the sprite RLE encoder and the bind that attaches it.
// Depends on strle_pkg and sprite_transparency_rle_encoder_macros.svh.
`default_nettype none
`include "sprite_transparency_rle_encoder_macros.svh"

module strle_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [strle_pkg::CHUNK_W-1:0]     out_chunk,
  input logic [strle_pkg::BC_W-1:0]        out_byte_count,
  input logic                              out_row_done,
  input logic                              out_last_of_burst
);
  import strle_pkg::*;

  logic count_ok, not_last_full, high_zero, row_end_seen, stalled, held_ok;
  logic [CHUNK_W+BC_W+1:0] out_word, last_word_r;

  assign count_ok      = (out_byte_count >= BC_W'(1)) && (out_byte_count <= BC_W'(CHUNK_BYTES));
  assign not_last_full = out_last_of_burst || (out_byte_count == BC_W'(CHUNK_BYTES));
  assign high_zero     = (out_byte_count >= BC_W'(CHUNK_BYTES)) ||
                         ((out_chunk >> {out_byte_count[CNT_W-1:0], 3'b000}) == '0);
  assign row_end_seen  = !out_empty && out_row_done;

  // A held transaction keeps every field; the previous cycle's fields are kept here.
  assign out_word = {out_chunk, out_byte_count, out_row_done, out_last_of_burst};
  assign stalled  = !out_empty && !out_pop;
  assign held_ok  = !out_empty && (out_word == last_word_r);

  always_ff @(posedge clk) begin
    last_word_r <= out_word;
  end

  `STRLE_ASSERT_IMP(a_count_range, !out_empty, count_ok, "byte count out of range")
  `STRLE_ASSERT_IMP(a_row_done_last, row_end_seen, out_last_of_burst, "row end not on last chunk")
  `STRLE_ASSERT_IMP(a_inner_chunk_full, !out_empty, not_last_full, "inner chunk not full")
  `STRLE_ASSERT_IMP(a_unused_bytes_zero, !out_empty, high_zero, "unused chunk bytes not zero")
  `STRLE_ASSERT_NXT(a_hold_stalled, stalled, held_ok, "stalled transaction changed")

endmodule

bind sprite_transparency_rle_encoder strle_checker u_strle_checker (.*);

`default_nettype wire

// ===== bench/strle_chunk_checker.sv =====
// Checker for the sprite RLE encoder: watches the pixel, result and register ports,
// predicts the encoded chunks of every accepted pixel and compares them in order.
// Depends on strle_pkg for widths, limits and byte codes.
`default_nettype none

module strle_chunk_checker
  import strle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [CHUNK_W-1:0] out_chunk,
  input  logic [BC_W-1:0]    out_byte_count,
  input  logic               out_row_done,
  input  logic               out_last_of_burst,
  output int                 error_count,
  output int                 chunks_open
);

  typedef struct packed {
    logic [CHUNK_W-1:0] data;
    logic [BC_W-1:0]    count;
    logic               row_done;
    logic               last;
  } chunk_t;

  chunk_t           pending_chunks[$];
  logic [PIX_W-1:0] burst_bytes[$];
  logic [PIX_W-1:0] run_buf [0:MAX_RUN-1];
  int               run_len;
  logic             run_clear;
  int               column;
  logic [CFG_W-1:0] row_width;
  int               mismatches = 0;

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Emits the pending run into the burst; a transparent run ending the row is dropped.
  task flush_run(input logic at_row_end);
    int i;
    if (run_len != 0) begin
      if (!run_clear) begin
        burst_bytes.push_back(8'(run_len));
        for (i = 0; i < run_len; i++) burst_bytes.push_back(run_buf[i]);
      end else if (!at_row_end) begin
        burst_bytes.push_back(CLEAR_FLAG | 8'(run_len));
      end
      run_len = 0;
    end
  endtask

  task encode_pixel(input logic [PIX_W-1:0] p);
    int     w;
    int     base;
    int     cnt;
    int     j;
    logic   clear;
    logic   row_end;
    chunk_t c;
    w = row_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    clear = (p == '0);
    row_end = 1'b0;
    burst_bytes.delete();
    if (run_len != 0 && (clear != run_clear || run_len >= MAX_RUN)) flush_run(1'b0);
    if (run_len == 0) run_clear = clear;
    run_buf[run_len] = p;
    run_len++;
    if (column + 1 >= w) begin
      flush_run(1'b1);
      burst_bytes.push_back(ROW_END_MARK);
      column = 0;
      row_end = 1'b1;
    end else begin
      column++;
    end
    for (base = 0; base < burst_bytes.size(); base += CHUNK_BYTES) begin
      cnt = burst_bytes.size() - base;
      if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
      c.data = '0;
      for (j = 0; j < cnt; j++) c.data[PIX_W*j +: PIX_W] = burst_bytes[base + j];
      c.count = BC_W'(cnt);
      c.last = (base + CHUNK_BYTES >= burst_bytes.size());
      c.row_done = row_end && c.last;
      pending_chunks.push_back(c);
    end
  endtask

  task check_chunk();
    chunk_t want;
    if (pending_chunks.size() == 0) begin
      report_mismatch("unexpected chunk", out_chunk, '0);
    end else begin
      want = pending_chunks.pop_front();
      if (out_chunk !== want.data) report_mismatch("chunk", out_chunk, want.data);
      if (out_byte_count !== want.count)
        report_mismatch("byte_count", 64'(out_byte_count), 64'(want.count));
      if (out_row_done !== want.row_done)
        report_mismatch("row_done", 64'(out_row_done), 64'(want.row_done));
      if (out_last_of_burst !== want.last)
        report_mismatch("last_of_burst", 64'(out_last_of_burst), 64'(want.last));
    end
  endtask

  // A pixel taken at the same edge as a register write still sees the old width.
  always @(posedge clk) begin
    if (!rst_n) begin
      run_len = 0;
      run_clear = 1'b0;
      column = 0;
      row_width = CFG_W'(1);
      pending_chunks.delete();
    end else begin
      if (in_push && !in_full) encode_pixel(in_pixel);
      if (cfg_wr_en) row_width = cfg_wr_data;
      if (out_pop && !out_empty) check_chunk();
    end
    error_count <= mismatches;
    chunks_open <= pending_chunks.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Top of the sprite RLE encoder testbench: clock, reset, pixel and pop stimulus, verdict.
// Depends on strle_pkg, sprite_transparency_rle_encoder and strle_chunk_checker.
`default_nettype none

module tb_top;
  import strle_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_PCT       = 31;
  localparam int SETTLE_CYCLES  = 20;
  localparam int END_CYCLES     = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 290;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [CHUNK_W-1:0] out_chunk;
  logic [BC_W-1:0]    out_byte_count;
  logic               out_row_done;
  logic               out_last_of_burst;

  int error_count;
  int chunks_open;

  // Shared between the pixel process and the pop process. Both are written with
  // nonblocking assignments so the reader always sees the value of the previous edge.
  logic calm = 1'b0;      // no idling on either side while set
  logic hold_req = 1'b0;  // asks the pop process for one long hold-off

  int idle_cycles = 0;
  int random_items = 0;
  int run_left = 0;
  logic run_zero = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_transparency_rle_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel          (in_pixel),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_chunk         (out_chunk),
    .out_byte_count    (out_byte_count),
    .out_row_done      (out_row_done),
    .out_last_of_burst (out_last_of_burst)
  );

  strle_chunk_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel          (in_pixel),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_chunk         (out_chunk),
    .out_byte_count    (out_byte_count),
    .out_row_done      (out_row_done),
    .out_last_of_burst (out_last_of_burst),
    .error_count       (error_count),
    .chunks_open       (chunks_open)
  );

  // Offers one pixel, after a random number of idle cycles, and returns at the edge
  // where the transaction is accepted. Outputs are read right after the edge, so
  // they still hold the values the block presented at that edge.
  task automatic push_pixel(input logic [PIX_W-1:0] p);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push  <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // The register may only change while the block is idle. One extra edge first lets
  // the checker count the expectations of the last accepted pixel; the settle
  // period then covers a block that is still finishing its last burst internally.
  task automatic set_row_width(input logic [CFG_W-1:0] w);
    in_push <= 1'b0;
    @(posedge clk);
    while (chunks_open != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed runs of random kind and length with random opaque values;
  // one pixel in ten is plain noise that may break a run anywhere.
  task automatic next_pixel(output logic [PIX_W-1:0] p);
    if ($urandom_range(0, 9) == 0) begin
      p = PIX_W'($urandom_range(0, 255));
    end else begin
      if (run_left == 0) begin
        run_zero = ($urandom_range(0, 9) < 4);
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      p = run_zero ? '0 : PIX_W'($urandom_range(1, 255));
    end
  endtask

  // One phase: a new row width, then a random number of pixels. The count does not
  // line up with rows, so the next phase often changes the width mid row.
  task automatic small_phase();
    int               r;
    int               w;
    int               n;
    logic [PIX_W-1:0] p;
    r = $urandom_range(0, 15);
    if (r == 0) w = 0;
    else if (r == 1) w = $urandom_range(20, 60);
    else w = $urandom_range(1, 12);
    set_row_width(CFG_W'(w));
    n = $urandom_range(1, 2 * ((w == 0) ? 1 : w) + 6);
    repeat (n) begin
      next_pixel(p);
      push_pixel(p);
      random_items++;
    end
  endtask

  // Pop side. It pops at random, never idles while calm is set, and once on request
  // holds off for a long stretch so that the block fills up and raises in_full.
  initial begin : pop_side
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: counts edges at which no transaction is accepted on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : pixel_side
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width is one: every pixel is a full row. A transparent pixel leaves
    // only the row end marker, an opaque one its run and then the marker.
    push_pixel(8'h00);
    push_pixel(8'hff);
    push_pixel(8'h01);

    // Width zero behaves as width one.
    set_row_width(13'd0);
    push_pixel(8'h80);
    push_pixel(8'h00);

    // Three-pixel rows: a transparent tail is dropped, a transparent head is flushed
    // with its length, an all-transparent row is the marker alone.
    set_row_width(13'd3);
    push_pixel(8'h55); push_pixel(8'haa); push_pixel(8'h00);
    push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h07);
    push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'h00);
    push_pixel(8'h09); push_pixel(8'h00); push_pixel(8'h09);

    // Widest row, then a width beyond the maximum which saturates, then a width
    // below the current column, so the very next pixel has to end the row.
    set_row_width(13'd4096);
    push_pixel(8'h12);
    push_pixel(8'h00);
    set_row_width(13'h1fff);
    push_pixel(8'h00);
    set_row_width(13'd2);
    push_pixel(8'h34);

    // An opaque row one longer than the run limit: the last pixel flushes a full
    // run and ends the row with its own run, the longest burst the block makes.
    // Both long rows run without idling on either side.
    set_row_width(13'd128);
    calm <= 1'b1;
    for (i = 0; i < 128; i++) push_pixel(PIX_W'($urandom_range(1, 255)));
    random_items += 128;
    // A transparent row of the same width: the full run is flushed on the limit,
    // the one-pixel remainder is dropped at row end.
    for (i = 0; i < 128; i++) push_pixel('0);
    random_items += 128;
    calm <= 1'b0;

    // One-pixel rows make a result per pixel, so the long hold-off fills the block.
    set_row_width(13'd1);
    hold_req <= 1'b1;
    for (i = 0; i < 16; i++) push_pixel(PIX_W'($urandom_range(0, 255)));
    random_items += 16;

    while (random_items < RANDOM_ITEMS) small_phase();

    // Drain: wait for every predicted chunk, then watch for stray results.
    in_push <= 1'b0;
    @(posedge clk);
    while (chunks_open != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/strle_pkg.sv
design/strle_ram.sv
design/strle_front.sv
design/strle_queue.sv
design/strle_back.sv
design/sprite_transparency_rle_encoder.sv
design/strle_checker.sv
bench/strle_chunk_checker.sv
bench/tb_top.sv
